FILE: src/pvis_pkg.sv
package pvis_pkg;

    localparam int LENGTH_BITS  = 28;
    localparam int MAX_BYTES_W  = 27;
    localparam int WINDOW_DEPTH = 22;
    localparam int LANG_CNT_W   = 4;
    localparam int OUT_DATA_W   = 88;

    typedef logic [7:0]                    t_byte;
    typedef logic [WINDOW_DEPTH-1:0][7:0]  t_window;
    typedef logic [LENGTH_BITS-1:0]        t_offset;
    typedef logic [MAX_BYTES_W-1:0]        t_max_bytes;
    typedef logic [1:0]                    t_status;

    localparam t_max_bytes MAX_BYTES_RESET = 27'd104857600;

    localparam t_status STATUS_OK        = 2'd0;
    localparam t_status STATUS_TOO_LARGE = 2'd1;
    localparam t_status STATUS_NO_VERSION = 2'd2;

    localparam t_byte SIG_BYTE0 = 8'hBD;
    localparam t_byte SIG_BYTE1 = 8'h04;
    localparam t_byte SIG_BYTE2 = 8'hEF;
    localparam t_byte SIG_BYTE3 = 8'hFE;

    localparam t_byte MAGIC_M = 8'h4D;
    localparam t_byte MAGIC_Z = 8'h5A;

    localparam logic [31:0] STRUCT_VER_HIGH_MASK = 32'hFFFF0000;

    // "Translation" in UTF-16LE, first byte of the key first.
    localparam t_byte TRANSLATION_KEY [WINDOW_DEPTH] = '{
        8'h54, 8'h00, 8'h72, 8'h00, 8'h61, 8'h00, 8'h6E, 8'h00,
        8'h73, 8'h00, 8'h6C, 8'h00, 8'h61, 8'h00, 8'h74, 8'h00,
        8'h69, 8'h00, 8'h6F, 8'h00, 8'h6E, 8'h00
    };

endpackage

FILE: src/pvis_cell.sv
module pvis_cell (
    input  logic             i_clk,
    input  logic             i_shift,
    input  pvis_pkg::t_byte  i_byte,
    output pvis_pkg::t_byte  o_byte
);
    import pvis_pkg::*;

    t_byte r_byte;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

FILE: src/pvis_window.sv
module pvis_window (
    input  logic              i_clk,
    input  logic              i_shift,
    input  pvis_pkg::t_byte   i_byte,
    output pvis_pkg::t_window o_window
);
    import pvis_pkg::*;

    // Entry k holds the byte k positions before the incoming one.
    t_window w_win;

    assign w_win[0] = i_byte;

    genvar k;
    generate
        for (k = 1; k < WINDOW_DEPTH; k++) begin : g_cell
            pvis_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (i_shift),
                .i_byte  (w_win[k-1]),
                .o_byte  (w_win[k])
            );
        end
    endgenerate

    assign o_window = w_win;

endmodule

FILE: src/pe_version_info_scanner.sv
// The result appears in the output register in the cycle after the
// transfer of the byte marked last.
// Throughput: one byte per cycle; the window row shifts on every scanned byte.
// While a result waits on a stalled receiver, every input byte stalls with it.
// Reset (i_rst_n low, synchronous) clears the scan control state and the
// output valid flag and sets the size limit to 104857600 bytes.
module pe_version_info_scanner (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  pvis_pkg::t_max_bytes     i_cfg_wr_data,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [7:0]               s_axis_tdata,   // byte_value
    input  logic                     s_axis_tlast,   // last_byte
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // status[1:0], major[17:2], minor[33:18], build_number[49:34],
    // revision[65:50], language_id[81:66], zero fill[87:82]
    output logic [87:0]              m_axis_tdata
);
    import pvis_pkg::*;

    t_max_bytes              r_max_bytes;
    t_offset                 r_offset,   n_offset;
    logic                    r_magic,    n_magic;
    logic                    r_vfound,   n_vfound;
    logic [31:0]             r_vhigh,    n_vhigh;
    logic [31:0]             r_vlow,     n_vlow;
    logic                    r_tseen,    n_tseen;
    logic [LANG_CNT_W-1:0]   r_lcnt,     n_lcnt;
    logic                    r_lang_ok,  n_lang_ok;
    logic [15:0]             r_lang_val, n_lang_val;
    logic                    r_out_valid;
    logic [OUT_DATA_W-1:0]   r_out_data, n_out_data;

    logic     w_fire;
    logic     w_scan;
    t_window  w;
    logic     w_sig_hit;
    logic     w_key_hit;
    logic [31:0] w_struct_ver;
    t_status  w_status;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_fire        = s_axis_tvalid && s_axis_tready;
    assign w_scan        = w_fire && (r_offset != '1);

    pvis_window u_window (
        .i_clk    (i_clk),
        .i_shift  (w_scan),
        .i_byte   (s_axis_tdata),
        .o_window (w)
    );

    assign w_struct_ver = {w[8], w[9], w[10], w[11]};

    always_comb begin
        w_sig_hit = (r_offset >= t_offset'(15)) && (r_offset[1:0] == 2'b11) &&
                    (w[15] == SIG_BYTE0) && (w[14] == SIG_BYTE1) &&
                    (w[13] == SIG_BYTE2) && (w[12] == SIG_BYTE3);
        w_key_hit = (r_offset >= t_offset'(21)) && r_offset[0];
        for (int j = 0; j < WINDOW_DEPTH; j++) begin
            if (w[WINDOW_DEPTH-1-j] != TRANSLATION_KEY[j]) begin
                w_key_hit = 1'b0;
            end
        end
    end

    always_comb begin
        n_offset   = r_offset;
        n_magic    = r_magic;
        n_vfound   = r_vfound;
        n_vhigh    = r_vhigh;
        n_vlow     = r_vlow;
        n_tseen    = r_tseen;
        n_lcnt     = r_lcnt;
        n_lang_ok  = r_lang_ok;
        n_lang_val = r_lang_val;

        if (w_scan) begin
            n_offset = r_offset + t_offset'(1);
            if ((r_offset == t_offset'(1)) && (w[1] == MAGIC_M) && (w[0] == MAGIC_Z)) begin
                n_magic = 1'b1;
            end
            if (!r_vfound && w_sig_hit &&
                ((w_struct_ver == 32'd0) ||
                 ((w_struct_ver & STRUCT_VER_HIGH_MASK) != 32'd0))) begin
                n_vfound = 1'b1;
                n_vhigh  = {w[4], w[5], w[6], w[7]};
                n_vlow   = {w[0], w[1], w[2], w[3]};
            end
            // The counter runs down to the fourth byte of the language word;
            // the word itself sits three and two steps before that.
            if (r_tseen && (r_lcnt != '0)) begin
                n_lcnt = r_lcnt - LANG_CNT_W'(1);
                if (r_lcnt == LANG_CNT_W'(4)) begin
                    n_lang_val[7:0] = w[0];
                end
                if (r_lcnt == LANG_CNT_W'(3)) begin
                    n_lang_val[15:8] = w[0];
                end
                if (r_lcnt == LANG_CNT_W'(1)) begin
                    n_lang_ok = 1'b1;
                end
            end
            if (!r_tseen && w_key_hit) begin
                n_tseen = 1'b1;
                n_lcnt  = r_offset[1] ? LANG_CNT_W'(8) : LANG_CNT_W'(6);
            end
        end

        if ({1'b0, n_offset} > {2'b00, r_max_bytes}) begin
            w_status = STATUS_TOO_LARGE;
        end else if (!n_magic || !n_vfound) begin
            w_status = STATUS_NO_VERSION;
        end else begin
            w_status = STATUS_OK;
        end

        n_out_data = '0;
        n_out_data[1:0] = w_status;
        if (w_status == STATUS_OK) begin
            n_out_data[17:2]  = n_vhigh[31:16];
            n_out_data[33:18] = n_vhigh[15:0];
            n_out_data[49:34] = n_vlow[31:16];
            n_out_data[65:50] = n_vlow[15:0];
            if (n_tseen && n_lang_ok) begin
                n_out_data[81:66] = n_lang_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bytes <= MAX_BYTES_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_bytes <= i_cfg_wr_data;
        end
    end

    // Control state clears at reset and again after each file's answer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_fire && s_axis_tlast)) begin
            r_offset  <= '0;
            r_magic   <= 1'b0;
            r_vfound  <= 1'b0;
            r_tseen   <= 1'b0;
            r_lcnt    <= '0;
            r_lang_ok <= 1'b0;
        end else begin
            r_offset  <= n_offset;
            r_magic   <= n_magic;
            r_vfound  <= n_vfound;
            r_tseen   <= n_tseen;
            r_lcnt    <= n_lcnt;
            r_lang_ok <= n_lang_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vhigh    <= n_vhigh;
        r_vlow     <= n_vlow;
        r_lang_val <= n_lang_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && s_axis_tlast) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && s_axis_tlast) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

FILE: sim/tb_pe_version_info_scanner.sv
`timescale 1ns / 1ps

module tb_pe_version_info_scanner;
    import pvis_pkg::*;

    typedef struct {
        t_byte value;
        logic  last;
    } t_file_byte;

    typedef struct {
        t_status     status;
        logic [15:0] major;
        logic [15:0] minor;
        logic [15:0] build_number;
        logic [15:0] revision;
        logic [15:0] language_id;
    } t_version_report;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    t_max_bytes  i_cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // byte_value
    logic        s_axis_tlast = 1'b0;  // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // status[1:0], major[17:2], minor[33:18], build_number[49:34],
    // revision[65:50], language_id[81:66], zero fill[87:82]
    logic [87:0] m_axis_tdata;

    t_file_byte      pending_bytes[$];
    t_version_report expected_reports[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int recv_hold_len = 0;
    int recv_hold_tag = 0;
    int seen_hold_tag = 0;
    int hold_left = 0;
    int fail_count = 0;

    // Scanner state as the block should hold it.
    t_max_bytes            cfg_max_bytes = MAX_BYTES_RESET;
    t_window               window = '0;
    t_offset               file_len = '0;
    logic                  mz_ok = 1'b0;
    logic                  ver_found = 1'b0;
    logic [31:0]           ver_high = '0;
    logic [31:0]           ver_low = '0;
    logic                  key_seen = 1'b0;
    logic [LENGTH_BITS:0]  lang_pos = '0;
    logic [LENGTH_BITS:0]  lang_need = '0;
    logic [15:0]           lang_word = '0;

    pe_version_info_scanner u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Advances the expected scan by one accepted byte and, on the last byte,
    // queues the report for the whole file.
    function automatic void scan_file_byte(t_byte b, logic last);
        t_offset         n;
        logic [31:0]     struct_word;
        logic            key_hit;
        t_version_report rep;
        int              j;
        if (file_len != '1) begin
            n = file_len;
            window = {window[WINDOW_DEPTH-2:0], b};
            if (n == 1 && window[1] == MAGIC_M && window[0] == MAGIC_Z)
                mz_ok = 1'b1;
            // Signature starts at n-15, which must be a multiple of four.
            if (!ver_found && n >= 15 && n[1:0] == 2'd3 &&
                window[15] == SIG_BYTE0 && window[14] == SIG_BYTE1 &&
                window[13] == SIG_BYTE2 && window[12] == SIG_BYTE3) begin
                struct_word = {window[8], window[9], window[10], window[11]};
                if (struct_word == 0 || (struct_word & STRUCT_VER_HIGH_MASK) != 0) begin
                    ver_high = {window[4], window[5], window[6], window[7]};
                    ver_low  = {window[0], window[1], window[2], window[3]};
                    ver_found = 1'b1;
                end
            end
            if (key_seen) begin
                if ({1'b0, n} == lang_pos)
                    lang_word[7:0] = b;
                else if ({1'b0, n} == lang_pos + (LENGTH_BITS+1)'(1))
                    lang_word[15:8] = b;
            end
            // The key starts at n-21, which must be even.
            if (!key_seen && n >= 21 && n[0]) begin
                key_hit = 1'b1;
                for (j = 0; j < WINDOW_DEPTH; j++)
                    if (window[WINDOW_DEPTH-1-j] != TRANSLATION_KEY[j])
                        key_hit = 1'b0;
                if (key_hit) begin
                    lang_pos  = ({1'b0, n} + (LENGTH_BITS+1)'(6)) &
                                ~(LENGTH_BITS+1)'(3);
                    lang_need = lang_pos + (LENGTH_BITS+1)'(4);
                    key_seen  = 1'b1;
                end
            end
            file_len = n + t_offset'(1);
        end
        if (last) begin
            rep = '{default: '0};
            if (file_len > cfg_max_bytes) begin
                rep.status = STATUS_TOO_LARGE;
            end else if (!mz_ok || !ver_found) begin
                rep.status = STATUS_NO_VERSION;
            end else begin
                rep.status       = STATUS_OK;
                rep.major        = ver_high[31:16];
                rep.minor        = ver_high[15:0];
                rep.build_number = ver_low[31:16];
                rep.revision     = ver_low[15:0];
                if (key_seen && {1'b0, file_len} >= lang_need)
                    rep.language_id = lang_word;
            end
            expected_reports.push_back(rep);
            window = '0;
            file_len = '0;
            mz_ok = 1'b0;
            ver_found = 1'b0;
            ver_high = '0;
            ver_low = '0;
            key_seen = 1'b0;
            lang_pos = '0;
            lang_need = '0;
            lang_word = '0;
        end
    endfunction

    function automatic void push_byte(t_byte b, logic last);
        t_file_byte fb;
        fb.value = b;
        fb.last = last;
        pending_bytes.push_back(fb);
    endfunction

    // Builds one file image and queues it; returns its length. Shaped files mostly
    // start with the mark and carry signatures and translation keys at random places.
    function automatic int queue_file(bit shaped);
        t_byte       img [0:159];
        int          len, cur, pos, k;
        logic [31:0] struct_word;
        for (k = 0; k < 160; k++)
            img[k] = ($urandom_range(3) == 0) ? 8'h00 : t_byte'($urandom);
        if (!shaped) begin
            len = $urandom_range(1, 24);
            if ($urandom_range(1) == 0) begin
                img[0] = MAGIC_M;
                img[1] = ($urandom_range(3) == 0) ? t_byte'($urandom) : MAGIC_Z;
            end
        end else begin
            if ($urandom_range(9) != 0) begin
                img[0] = MAGIC_M;
                img[1] = MAGIC_Z;
            end
            cur = 2;
            repeat ($urandom_range(1, 3)) begin
                cur += $urandom_range(0, 6);
                if ($urandom_range(1) == 0) begin
                    pos = (cur + 3) & ~3;
                    if ($urandom_range(7) == 0)
                        pos += 2;
                    case ($urandom_range(3))
                        0: struct_word = 32'h0;
                        1: struct_word = 32'h0001_0000;
                        2: struct_word = {16'($urandom_range(1, 65535)), 16'($urandom)};
                        default: struct_word = 32'($urandom_range(1, 65535));
                    endcase
                    img[pos]   = SIG_BYTE0;
                    img[pos+1] = SIG_BYTE1;
                    img[pos+2] = SIG_BYTE2;
                    img[pos+3] = SIG_BYTE3;
                    for (k = 0; k < 4; k++)
                        img[pos+4+k] = struct_word[8*k +: 8];
                    cur = pos + 16;
                end else begin
                    pos = (cur + 1) & ~1;
                    if ($urandom_range(7) == 0)
                        pos += 1;
                    for (k = 0; k < WINDOW_DEPTH; k++)
                        img[pos+k] = TRANSLATION_KEY[k];
                    cur = ((pos + 27) & ~3) + 4;
                end
            end
            len = cur + $urandom_range(0, 5);
            // Sometimes cut the file short inside the last structure.
            if ($urandom_range(3) == 0)
                len -= $urandom_range(1, 8);
            if (len < 1)
                len = 1;
        end
        for (k = 0; k < len; k++)
            push_byte(img[k], k == len - 1);
        return len;
    endfunction

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || s_axis_tvalid || expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_phase(t_max_bytes max_bytes, int send_pct, int recv_pct,
                             int byte_target, bit long_hold);
        int queued;
        wait_drained();
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= max_bytes;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cfg_max_bytes = max_bytes;
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        queued = 0;
        if (long_hold) begin
            // Short files back up behind a stopped receiver.
            recv_hold_len = 400;
            recv_hold_tag++;
            repeat (10)
                queued += queue_file(1'b0);
        end
        while (queued < byte_target)
            queued += queue_file($urandom_range(9) < 6);
    endtask

    // Byte driver; the expected scan advances on every accepted transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                scan_file_byte(s_axis_tdata, s_axis_tlast);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= pending_bytes[0].value;
                    s_axis_tlast <= pending_bytes[0].last;
                    void'(pending_bytes.pop_front());
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(string name, logic [15:0] exp_val,
                                        logic [15:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected %h, got %h", name, exp_val, act_val);
            fail_count++;
        end
    endfunction

    // Report monitor and receiver backpressure.
    always @(posedge i_clk) begin
        t_version_report exp_rep;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_reports.size() == 0) begin
                    $error("report transfer with nothing expected: %h", m_axis_tdata);
                    fail_count++;
                end else begin
                    exp_rep = expected_reports.pop_front();
                    check_field("status", 16'(exp_rep.status), 16'(m_axis_tdata[1:0]));
                    check_field("major", exp_rep.major, m_axis_tdata[17:2]);
                    check_field("minor", exp_rep.minor, m_axis_tdata[33:18]);
                    check_field("build_number", exp_rep.build_number, m_axis_tdata[49:34]);
                    check_field("revision", exp_rep.revision, m_axis_tdata[65:50]);
                    check_field("language_id", exp_rep.language_id, m_axis_tdata[81:66]);
                end
            end
            if (recv_hold_tag != seen_hold_tag) begin
                seen_hold_tag <= recv_hold_tag;
                hold_left <= recv_hold_len;
                m_axis_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Smallest complete version block: mark, padding, signature with a
        // common structure word, then all-ones and all-zeros version words.
        push_byte(MAGIC_M, 1'b0);
        push_byte(MAGIC_Z, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(SIG_BYTE0, 1'b0);
        push_byte(SIG_BYTE1, 1'b0);
        push_byte(SIG_BYTE2, 1'b0);
        push_byte(SIG_BYTE3, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h00, 1'b0);
        repeat (4) push_byte(8'hFF, 1'b0);
        repeat (3) push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b1);
        // One-byte files and a file that is only the mark.
        push_byte(8'hFF, 1'b1);
        push_byte(8'h00, 1'b1);
        push_byte(MAGIC_M, 1'b0);
        push_byte(MAGIC_Z, 1'b1);

        run_phase({MAX_BYTES_W{1'b1}}, 0, 0, 400, 1'b1);
        run_phase('0, 82, 0, 150, 1'b0);
        run_phase(t_max_bytes'($urandom_range(20, 60)), 0, 82, 400, 1'b0);
        run_phase(t_max_bytes'($urandom), 12, 12, 400, 1'b0);
        run_phase(t_max_bytes'(45), 0, 0, 350, 1'b0);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #6000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: sim.f
src/pvis_pkg.sv
src/pvis_cell.sv
src/pvis_window.sv
src/pe_version_info_scanner.sv
sim/tb_pe_version_info_scanner.sv
